FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the UTF-8 stream decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/utf8sd_pkg.sv
// Types, constants and helper functions of the UTF-8 stream decoder.
package utf8sd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CP_W     = 21;
	localparam int unsigned BUF_D    = 4;
	localparam int unsigned CNT_W    = 3;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CP_W-1:0]   cp_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LEAD = 4'b0010,
		ST_CONT = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	// Sequence length from the lead byte; zero marks an invalid lead.
	function automatic cnt_t lead_len(input byte_t b);
		cnt_t len;
		if (b[7] == 1'b0) begin
			len = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

	// Payload bits carried by the lead byte of a sequence of the given length.
	function automatic cp_t lead_bits(input byte_t b, input cnt_t len);
		cp_t cp;
		case (len)
			3'd1:    cp = {13'd0, b};
			3'd2:    cp = {16'd0, b[4:0]};
			3'd3:    cp = {17'd0, b[3:0]};
			default: cp = {18'd0, b[2:0]};
		endcase
		return cp;
	endfunction

endpackage

FILE: rtl/utf8sd_in_if.sv
// Byte request channel into the UTF-8 stream decoder.
interface utf8sd_in_if;
	import utf8sd_pkg::*;

	logic  valid;
	logic  ready;
	byte_t byte_value;
	logic  text_end;

	modport source (output valid, output byte_value, output text_end, input ready);
	modport sink   (input valid, input byte_value, input text_end, output ready);
endinterface

FILE: rtl/utf8sd_out_if.sv
// Code point request channel out of the UTF-8 stream decoder.
interface utf8sd_out_if;
	import utf8sd_pkg::*;

	logic valid;
	logic ready;
	cp_t  code_point;
	logic malformed;
	logic final_result;

	modport source (output valid, output code_point, output malformed,
		output final_result, input ready);
	modport sink   (input valid, input code_point, input malformed,
		input final_result, output ready);
endinterface

FILE: rtl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder: one byte in, zero or more code points out, under a small sequencer.
//
// The decoder takes one byte per request on rx and holds up to three bytes of an
// incomplete sequence. A byte is accepted only while the sequencer is idle. Each
// decoded code point then passes through the sequencer: the lead byte is inspected
// in ST_LEAD, each continuation byte goes through the shared shift-and-merge unit in
// ST_CONT, and the output register is loaded in ST_EMIT, which waits while tx
// stalls. At the end of each byte ST_LEAD finds the buffer empty or the sequence
// still incomplete and returns to idle, so a byte that completes nothing passes only
// through ST_IDLE and ST_LEAD. A replacement for a bad lead or for a sequence cut
// short by text_end passes through ST_LEAD and ST_EMIT only. A correct U+FFFD reports
// malformed low; a replacement reports it high. final_result marks the last code point
// caused by a byte flagged with text_end, and no bytes are held after such a byte.
module utf8_stream_decoder_unit (
	input  logic         clk,
	input  logic         arst_n,
	utf8sd_in_if.sink    rx,
	utf8sd_out_if.source tx
);
	import utf8sd_pkg::*;
	`include "assert_macros.svh"

	state_t state_q;
	byte_t  buf_q [BUF_D];
	cnt_t   n_q;
	logic   at_end_q;
	cnt_t   len_q;
	logic [1:0] idx_q;
	cnt_t   drop_q;
	cp_t    cp_q;
	logic   ok_q;

	logic   out_valid_q;
	cp_t    out_cp_q;
	logic   out_bad_q;
	logic   out_final_q;

	byte_t  lead;
	cnt_t   len;
	byte_t  cont;
	logic   cont_last;
	logic   out_free;
	logic   emit_fire;
	byte_t  buf_shift [BUF_D];

	// Decode of the front byte and the continuation byte under work.
	assign lead      = buf_q[0];
	assign len       = lead_len(lead);
	assign cont      = buf_q[idx_q];
	assign cont_last = (cnt_t'(idx_q) + 3'd1) == len_q;
	assign out_free  = !out_valid_q || tx.ready;
	assign emit_fire = (state_q == ST_EMIT) && out_free;

	// Buffer contents after dropping the consumed bytes from the front.
	always_comb begin
		cnt_t sel;
		for (int i = 0; i < BUF_D; i++) begin
			sel = cnt_t'(i) + drop_q;
			buf_shift[i] = sel[2] ? buf_q[i] : buf_q[sel[1:0]];
		end
	end

	assign rx.ready        = (state_q == ST_IDLE);
	assign tx.valid        = out_valid_q;
	assign tx.code_point   = out_cp_q;
	assign tx.malformed    = out_bad_q;
	assign tx.final_result = out_final_q;

	// Sequencer and byte buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			at_end_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rx.valid) begin
						n_q      <= n_q + 3'd1;
						at_end_q <= rx.text_end;
						state_q  <= ST_LEAD;
					end
				end
				ST_LEAD: begin
					if (n_q == 3'd0) begin
						state_q <= ST_IDLE;
					end else if (len == 3'd0 || (len > n_q && at_end_q)) begin
						state_q <= ST_EMIT;
					end else if (len > n_q) begin
						state_q <= ST_IDLE;
					end else if (len == 3'd1) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CONT;
					end
				end
				ST_CONT: begin
					if (cont_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						n_q     <= n_q - drop_q;
						state_q <= ST_LEAD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Byte storage and the shared shift-and-merge unit; payload needs no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && rx.valid) begin
			buf_q[n_q[1:0]] <= rx.byte_value;
		end
		if (emit_fire) begin
			buf_q <= buf_shift;
		end
		if (state_q == ST_LEAD) begin
			cp_q   <= lead_bits(lead, len);
			len_q  <= len;
			idx_q  <= 2'd1;
			drop_q <= 3'd1;
			ok_q   <= !(len == 3'd0 || len > n_q);
		end
		if (state_q == ST_CONT) begin
			cp_q  <= {cp_q[CP_W-7:0], cont[5:0]};
			idx_q <= idx_q + 2'd1;
			if (cont[7:6] != 2'b10) begin
				ok_q <= 1'b0;
			end
			if (cont_last) begin
				drop_q <= (ok_q && cont[7:6] == 2'b10) ? len_q : 3'd1;
			end
		end
		if (emit_fire) begin
			out_cp_q    <= ok_q ? cp_q : REPLACEMENT_CP;
			out_bad_q   <= !ok_q;
			out_final_q <= at_end_q && (n_q == drop_q);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`ASSERT_ALWAYS(a_count_range, clk, arst_n, n_q <= 3'd4, "byte count above buffer depth")
	`ASSERT_IMPLIES(a_idle_fits, clk, arst_n, state_q == ST_IDLE, n_q <= 3'd3, "idle with full buffer")
	`ASSERT_IMPLIES(a_end_flush, clk, arst_n, state_q == ST_IDLE && at_end_q, n_q == 3'd0, "bytes held after text end")
	`ASSERT_IMPLIES(a_cont_len, clk, arst_n, state_q == ST_CONT, len_q >= 3'd2 && len_q <= n_q, "continuation walk beyond buffered bytes")

endmodule
